/* sv/sfla_pkg.sv */
// Shared types, codes and constants of the segregated free list allocator.
package sfla_pkg;

    localparam int ENT_W       = 12;
    localparam int SIZE_W      = 32;
    localparam int TAG_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int SCAN_W      = 31;
    localparam int PERIOD_W    = 16;
    localparam int OP_W        = 2;
    localparam int LOG_W       = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_ENTITY_COUNT = 4096;
    localparam int DEF_BUCKET_COUNT = 16;
    localparam int DEF_SCAN_LIMIT   = 64;

    localparam logic [ENT_W-1:0]    FIRST_FREEABLE_RESET = 12'd1;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET         = 16'd1000;

    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WANT_GC   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_RECORD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREEABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLLECTION_PERIOD = 1'd1;

    typedef struct packed {
        logic              start;
        logic [SIZE_W-1:0] value;
    } log_req_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] bucket;
    } log_rsp_t;

endpackage

/* sv/sfla_log2_unit.sv */
// Iterative floor-log2 unit that maps a size onto its clamped size-class bucket.
module sfla_log2_unit
    import sfla_pkg::*;
#(
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  log_req_t req,
    output log_rsp_t rsp
);

    logic              busy_reg;
    logic [SIZE_W-1:0] value_reg;
    logic [LOG_W-1:0]  lg_reg;
    logic [LOG_W-1:0]  diff;
    logic [LOG_W-1:0]  clamped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && value_reg <= SIZE_W'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            value_reg <= req.value;
            lg_reg    <= '0;
        end else if (busy_reg && value_reg > SIZE_W'(1)) begin
            value_reg <= value_reg >> 1;
            lg_reg    <= lg_reg + LOG_W'(1);
        end
    end

    always_comb begin
        diff = lg_reg - LOG_W'(4);
        if (lg_reg <= LOG_W'(4)) begin
            clamped = '0;
        end else if ({1'b0, diff} > (LOG_W + 1)'(BUCKET_COUNT - 1)) begin
            clamped = LOG_W'(BUCKET_COUNT - 1);
        end else begin
            clamped = diff;
        end
    end

    assign rsp.done   = busy_reg && !req.start && (value_reg <= SIZE_W'(1));
    assign rsp.bucket = clamped;

endmodule

/* sv/segregated_free_list_allocator_top.sv */
// Top level of the segregated free list allocator: entity tables, bucket heads, sequencer.
//
// One request is taken at a time; s_ready is low while it is worked on. After reset a
// clearing pass writes every valid bit to zero, one entity a cycle, so no request is taken
// until all ENTITY_COUNT entities (4096 by default) are cleared; configuration writes are
// taken meanwhile. A record, and a free that is ignored or rejected up front, go straight
// from idle to the response. A free that is pushed first reads the entity tables, then
// finds floor(log2 size) in the shift-per-cycle log2 unit and pushes the entity on the
// bucket head. An allocate that is not answered with a collection request runs the log2
// unit, then visits buckets from that one upward; every list node examined costs one
// registered read of the entity tables, with at most SCAN_LIMIT nodes per bucket. A result
// waits in the output register until taken.
module segregated_free_list_allocator_top
    import sfla_pkg::*;
#(
    parameter int ENTITY_COUNT = DEF_ENTITY_COUNT,
    parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
    parameter int SCAN_LIMIT   = DEF_SCAN_LIMIT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_operation,
    input  logic [ENT_W-1:0]      s_entity_number,
    input  logic [SIZE_W-1:0]     s_byte_size,
    input  logic [TAG_W-1:0]      s_type_tag,
    input  logic                  s_initializing,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [ENT_W-1:0]      m_allocated_entity,
    output logic [SIZE_W-1:0]     m_reclaimed_size,
    output logic [SCAN_W-1:0]     m_scan_total
);

    localparam int AW  = $clog2(ENTITY_COUNT);
    localparam int BW  = $clog2(BUCKET_COUNT);
    localparam int SNW = $clog2(SCAN_LIMIT + 1);

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_FREE_CHK = 11'b00000000100,
        S_LOG     = 11'b00000001000,
        S_PUSH    = 11'b00000010000,
        S_START   = 11'b00000100000,
        S_NODE    = 11'b00001000000,
        S_EVAL    = 11'b00010000000,
        S_END     = 11'b00100000000,
        S_FIX     = 11'b01000000000,
        S_RESP    = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic [ENT_W-1:0]    first_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] countdown_reg;
    logic [SCAN_W-1:0]   scan_reg;
    logic [AW-1:0]       clr_reg;

    logic [OP_W-1:0]     op_reg;
    logic [ENT_W-1:0]    ent_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ENT_W-1:0]    alloc_reg;
    logic [SIZE_W-1:0]   recl_reg;

    logic [BW-1:0]       bucket_reg;
    logic [ENT_W-1:0]    cur_reg;
    logic [ENT_W-1:0]    prev_reg;
    logic                prev_head_reg;
    logic [SNW-1:0]      seen_reg;
    logic                found_reg;
    logic [ENT_W-1:0]    best_reg;
    logic [SIZE_W-1:0]   best_size_reg;
    logic [ENT_W-1:0]    best_link_reg;
    logic                best_head_reg;
    logic [ENT_W-1:0]    best_prev_reg;

    logic [ENT_W-1:0]    heads_reg [BUCKET_COUNT];

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ENT_W-1:0]    m_alloc_reg;
    logic [SIZE_W-1:0]   m_recl_reg;
    logic [SCAN_W-1:0]   m_scan_reg;

    logic [SIZE_W-1:0]   size_mem  [ENTITY_COUNT];
    logic [TAG_W-1:0]    tag_mem   [ENTITY_COUNT];
    logic                valid_mem [ENTITY_COUNT];
    logic [ENT_W-1:0]    link_mem  [ENTITY_COUNT];

    logic [SIZE_W-1:0]   size_q;
    logic [TAG_W-1:0]    tag_q;
    logic                valid_q;
    logic [ENT_W-1:0]    link_q;

    logic                rd_en;
    logic [ENT_W-1:0]    rd_ent;
    logic [AW-1:0]       rd_addr;
    logic                size_we;
    logic                tag_we;
    logic [ENT_W-1:0]    tag_ent;
    logic [TAG_W-1:0]    tag_wd;
    logic                valid_we;
    logic [AW-1:0]       valid_wa;
    logic                valid_wd;
    logic                link_we;
    logic [ENT_W-1:0]    link_ent;
    logic [ENT_W-1:0]    link_wd;

    logic [AW+ENT_W-1:0] rd_ext;
    logic [AW+ENT_W-1:0] in_ext;
    logic [AW+ENT_W-1:0] tag_ext;
    logic [AW+ENT_W-1:0] link_ext;

    log_req_t            log_req;
    log_rsp_t            log_rsp;

    logic                accept;
    logic                in_oob;
    logic                cur_oob;
    logic [PERIOD_W-1:0] count_dec;
    logic [SCAN_W-1:0]   scan_inc;
    logic                better;
    logic                out_free;

    function automatic logic oob(input logic [ENT_W-1:0] e);
        return {20'd0, e} >= 32'(ENTITY_COUNT);
    endfunction

    sfla_log2_unit #(
        .BUCKET_COUNT(BUCKET_COUNT)
    ) u_log2 (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (log_req),
        .rsp    (log_rsp)
    );

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign in_oob    = oob(s_entity_number);
    assign cur_oob   = oob(cur_reg);
    assign count_dec = countdown_reg - PERIOD_W'(1);
    assign scan_inc  = (scan_reg == {SCAN_W{1'b1}}) ? scan_reg : scan_reg + SCAN_W'(1);
    assign better    = (size_q >= size_reg) && (!found_reg || size_q < best_size_reg);
    assign out_free  = !m_valid_reg || m_ready;

    assign in_ext   = {{AW{1'b0}}, s_entity_number};
    assign rd_ext   = {{AW{1'b0}}, rd_ent};
    assign tag_ext  = {{AW{1'b0}}, tag_ent};
    assign link_ext = {{AW{1'b0}}, link_ent};
    assign rd_addr  = rd_ext[AW-1:0];

    always_comb begin
        log_req.start = 1'b0;
        log_req.value = size_reg;
        rd_en    = 1'b0;
        rd_ent   = cur_reg;
        size_we  = 1'b0;
        tag_we   = 1'b0;
        tag_ent  = ent_reg;
        tag_wd   = '0;
        valid_we = 1'b0;
        valid_wa = clr_reg;
        valid_wd = 1'b0;
        link_we  = 1'b0;
        link_ent = ent_reg;
        link_wd  = heads_reg[bucket_reg];
        unique case (state_reg)
            S_CLEAR: begin
                valid_we = 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    rd_ent = s_entity_number;
                    if (s_operation == OP_FREE) begin
                        rd_en = 1'b1;
                    end
                    if (s_operation == OP_ALLOC &&
                        (s_initializing || count_dec != '0)) begin
                        log_req.start = 1'b1;
                        log_req.value = s_byte_size;
                    end
                    if (s_operation == OP_RECORD && !in_oob) begin
                        size_we  = 1'b1;
                        tag_we   = 1'b1;
                        tag_ent  = s_entity_number;
                        tag_wd   = s_type_tag;
                        valid_we = 1'b1;
                        valid_wa = in_ext[AW-1:0];
                        valid_wd = 1'b1;
                    end
                end
            end
            S_FREE_CHK: begin
                if (valid_q && size_q != '0) begin
                    log_req.start = 1'b1;
                    log_req.value = size_q;
                end
            end
            S_PUSH: begin
                tag_we  = 1'b1;
                link_we = 1'b1;
            end
            S_NODE: begin
                rd_en = (cur_reg != '0) && (seen_reg != SNW'(SCAN_LIMIT)) && !cur_oob;
            end
            S_FIX: begin
                tag_we   = 1'b1;
                tag_ent  = best_reg;
                tag_wd   = tag_reg;
                link_we  = !best_head_reg;
                link_ent = best_prev_reg;
                link_wd  = best_link_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            size_q  <= size_mem[rd_addr];
            tag_q   <= tag_mem[rd_addr];
            valid_q <= valid_mem[rd_addr];
            link_q  <= link_mem[rd_addr];
        end
        if (size_we) begin
            size_mem[in_ext[AW-1:0]] <= s_byte_size;
        end
        if (tag_we) begin
            tag_mem[tag_ext[AW-1:0]] <= tag_wd;
        end
        if (valid_we) begin
            valid_mem[valid_wa] <= valid_wd;
        end
        if (link_we) begin
            link_mem[link_ext[AW-1:0]] <= link_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= FIRST_FREEABLE_RESET;
            period_reg <= PERIOD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FIRST_FREEABLE:    first_reg  <= cfg_wdata[ENT_W-1:0];
                CFG_COLLECTION_PERIOD: period_reg <= cfg_wdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_RESP && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            countdown_reg <= PERIOD_RESET;
            scan_reg      <= '0;
            for (int i = 0; i < BUCKET_COUNT; i++) begin
                heads_reg[i] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(ENTITY_COUNT - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        op_reg    <= s_operation;
                        ent_reg   <= s_entity_number;
                        size_reg  <= s_byte_size;
                        tag_reg   <= s_type_tag;
                        alloc_reg <= '0;
                        recl_reg  <= '0;
                        if (s_operation == OP_ALLOC) begin
                            if (!s_initializing && count_dec == '0) begin
                                countdown_reg <= period_reg;
                                status_reg    <= ST_WANT_GC;
                                state_reg     <= S_RESP;
                            end else begin
                                if (!s_initializing) begin
                                    countdown_reg <= count_dec;
                                end
                                state_reg <= S_LOG;
                            end
                        end else if (s_operation == OP_FREE) begin
                            if (s_entity_number < first_reg) begin
                                status_reg <= ST_IGNORED;
                                state_reg  <= S_RESP;
                            end else if (in_oob) begin
                                status_reg <= ST_INVALID;
                                state_reg  <= S_RESP;
                            end else begin
                                state_reg <= S_FREE_CHK;
                            end
                        end else if (s_operation == OP_RECORD) begin
                            status_reg <= in_oob ? ST_IGNORED : ST_DONE;
                            state_reg  <= S_RESP;
                        end else begin
                            status_reg <= ST_IGNORED;
                            state_reg  <= S_RESP;
                        end
                    end
                end
                S_FREE_CHK: begin
                    if (!valid_q) begin
                        status_reg <= ST_INVALID;
                        state_reg  <= S_RESP;
                    end else if (size_q == '0) begin
                        status_reg <= ST_IGNORED;
                        state_reg  <= S_RESP;
                    end else begin
                        size_reg  <= size_q;
                        state_reg <= S_LOG;
                    end
                end
                S_LOG: begin
                    if (log_rsp.done) begin
                        bucket_reg <= log_rsp.bucket[BW-1:0];
                        state_reg  <= (op_reg == OP_FREE) ? S_PUSH : S_START;
                    end
                end
                S_PUSH: begin
                    heads_reg[bucket_reg] <= ent_reg;
                    recl_reg   <= size_reg;
                    status_reg <= ST_DONE;
                    state_reg  <= S_RESP;
                end
                S_START: begin
                    cur_reg       <= heads_reg[bucket_reg];
                    seen_reg      <= '0;
                    found_reg     <= 1'b0;
                    prev_head_reg <= 1'b1;
                    prev_reg      <= '0;
                    state_reg     <= S_NODE;
                end
                S_NODE: begin
                    if (cur_reg == '0 || seen_reg == SNW'(SCAN_LIMIT)) begin
                        state_reg <= S_END;
                    end else if (cur_oob) begin
                        scan_reg   <= scan_inc;
                        status_reg <= ST_WANT_GC;
                        state_reg  <= S_RESP;
                        for (int i = 0; i < BUCKET_COUNT; i++) begin
                            heads_reg[i] <= '0;
                        end
                    end else begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    scan_reg <= scan_inc;
                    if (!valid_q || tag_q != '0) begin
                        status_reg <= ST_WANT_GC;
                        state_reg  <= S_RESP;
                        for (int i = 0; i < BUCKET_COUNT; i++) begin
                            heads_reg[i] <= '0;
                        end
                    end else begin
                        if (better) begin
                            found_reg     <= 1'b1;
                            best_reg      <= cur_reg;
                            best_size_reg <= size_q;
                            best_link_reg <= link_q;
                            best_head_reg <= prev_head_reg;
                            best_prev_reg <= prev_reg;
                        end
                        prev_head_reg <= 1'b0;
                        prev_reg      <= cur_reg;
                        cur_reg       <= link_q;
                        seen_reg      <= seen_reg + SNW'(1);
                        state_reg     <= (better && size_q == size_reg) ? S_FIX : S_NODE;
                    end
                end
                S_END: begin
                    if (found_reg) begin
                        state_reg <= S_FIX;
                    end else if (bucket_reg == BW'(BUCKET_COUNT - 1)) begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_RESP;
                    end else begin
                        bucket_reg <= bucket_reg + BW'(1);
                        state_reg  <= S_START;
                    end
                end
                S_FIX: begin
                    if (best_head_reg) begin
                        heads_reg[bucket_reg] <= best_link_reg;
                    end
                    alloc_reg  <= best_reg;
                    status_reg <= ST_DONE;
                    state_reg  <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_RESP && out_free) begin
            m_status_reg <= status_reg;
            m_alloc_reg  <= alloc_reg;
            m_recl_reg   <= recl_reg;
            m_scan_reg   <= scan_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_allocated_entity = m_alloc_reg;
    assign m_reclaimed_size   = m_recl_reg;
    assign m_scan_total       = m_scan_reg;

endmodule

/* sv/sfla_checker.sv */
// Port-level checker for the allocator top level, with its bind statement.
module sfla_checker
    import sfla_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [STATUS_W-1:0]   m_status,
    input logic [ENT_W-1:0]      m_allocated_entity,
    input logic [SIZE_W-1:0]     m_reclaimed_size
);

    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during the clearing pass");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
            $stable(m_allocated_entity))
        else $error("stalled result changed");

    a_fail_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_DONE |->
            m_allocated_entity == '0 && m_reclaimed_size == '0)
        else $error("failed request carries an entity or a size");

    a_alloc_not_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_allocated_entity != '0 |-> m_reclaimed_size == '0)
        else $error("result both allocates and reclaims");

endmodule

bind segregated_free_list_allocator_top sfla_checker u_sfla_checker (.*);
